@@ sv/slrd_pkg.sv @@
// slrd_pkg: shared types and constants of the skip/literal run-length line decoder
// no dependencies; used by every module of the decoder
`default_nettype none

package slrd_pkg;

    // configuration register map (byte addresses)
    localparam int unsigned ADDR_W = 3;
    localparam logic [0:0]  REG_LINE_WIDTH = 1'b0;   // word index of line_width

    localparam logic [15:0] LINE_WIDTH_RESET = 16'd640;

    // header byte counter codes
    localparam logic [2:0] HDR_PKT_LO = 3'd0;
    localparam logic [2:0] HDR_PKT_HI = 3'd1;
    localparam logic [2:0] HDR_POS_LO = 3'd2;
    localparam logic [2:0] HDR_POS_HI = 3'd3;
    localparam logic [2:0] HDR_DONE   = 3'd4;

    // one compressed input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_start;
    } t_in_beat;

    // one decoded result beat
    typedef struct packed {
        logic        pixel_valid;
        logic [15:0] pixel_x;
        logic [7:0]  pixel_value;
        logic        beyond_line;
        logic        line_done;
    } t_result;

endpackage

`default_nettype wire

@@ sv/slrd_in_stage.sv @@
// slrd_in_stage: input register of the decoder, holds one accepted beat
// depends on slrd_pkg for the beat type
`default_nettype none

module slrd_in_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  slrd_pkg::t_in_beat i_beat,
    input  wire                i_take,      // downstream consumes the held beat
    output logic               o_stall,
    output logic               o_held,
    output slrd_pkg::t_in_beat o_beat
);

    logic               r_valid;
    logic               n_valid;
    slrd_pkg::t_in_beat r_beat;
    logic               accept;

    // stall only while a beat is held and cannot move on
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

    assign o_held = r_valid;
    assign o_beat = r_beat;

endmodule

`default_nettype wire

@@ sv/slrd_core.sv @@
// slrd_core: line decoder state and its combinational update per byte
// depends on slrd_pkg for header codes and the result type
`default_nettype none

module slrd_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  slrd_pkg::t_in_beat i_beat,
    input  wire  [15:0]        i_line_width,
    output logic               o_has_result,
    output slrd_pkg::t_result  o_result
);

    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_pkts,    n_pkts;
    logic [15:0] r_pos,     n_pos;
    logic [7:0]  r_lit,     n_lit;
    logic        r_skip,    n_skip;
    logic [15:0] r_raw_left, n_raw_left;
    logic        r_raw,     n_raw;
    logic        r_fin,     n_fin;

    logic [7:0]  b;
    logic [15:0] pkts_dec;
    logic [15:0] raw_dec;
    logic        pix;
    logic        done;
    logic        emit;

    assign b        = i_beat.data_byte;
    assign pkts_dec = r_pkts - 16'd1;
    assign raw_dec  = r_raw_left - 16'd1;

    // next state and result for the byte in the input register
    always_comb begin
        n_hdr_idx  = r_hdr_idx;
        n_pkts     = r_pkts;
        n_pos      = r_pos;
        n_lit      = r_lit;
        n_skip     = r_skip;
        n_raw_left = r_raw_left;
        n_raw      = r_raw;
        n_fin      = r_fin;
        pix        = 1'b0;
        done       = 1'b0;
        emit       = 1'b0;

        if (i_beat.line_start) begin
            // new line: first header byte is the packet count low byte
            n_hdr_idx  = slrd_pkg::HDR_PKT_HI;
            n_pkts     = {8'd0, b};
            n_pos      = 16'd0;
            n_lit      = 8'd0;
            n_skip     = 1'b0;
            n_raw_left = 16'd0;
            n_raw      = 1'b0;
            n_fin      = 1'b0;
        end else if (r_fin) begin
            // idle, byte ignored
        end else if (r_hdr_idx != slrd_pkg::HDR_DONE) begin
            // remaining header bytes
            unique case (r_hdr_idx)
                slrd_pkg::HDR_PKT_HI: n_pkts = {b, r_pkts[7:0]};
                slrd_pkg::HDR_POS_LO: n_pos  = {8'd0, b};
                default:              n_pos  = {b, r_pos[7:0]};
            endcase
            n_hdr_idx = r_hdr_idx + 3'd1;
            if (n_hdr_idx == slrd_pkg::HDR_DONE && n_pkts == 16'd0) begin
                n_raw      = 1'b1;
                n_raw_left = i_line_width;
                if (i_line_width == 16'd0) begin
                    n_fin = 1'b1;
                    done  = 1'b1;
                    emit  = 1'b1;
                end
            end
        end else if (r_raw) begin
            // raw run: every byte is a pixel
            n_pos      = r_pos + 16'd1;
            n_raw_left = raw_dec;
            pix        = 1'b1;
            emit       = 1'b1;
            if (raw_dec == 16'd0) begin
                done  = 1'b1;
                n_fin = 1'b1;
            end
        end else if (r_lit != 8'd0) begin
            // pixel byte of a literal packet
            n_pos = r_pos + 16'd1;
            n_lit = r_lit - 8'd1;
            pix   = 1'b1;
            emit  = 1'b1;
            if (r_lit == 8'd1) begin
                n_skip = 1'b1;
                n_pkts = pkts_dec;
                if (pkts_dec == 16'd0) begin
                    done  = 1'b1;
                    n_fin = 1'b1;
                end
            end
        end else if (r_skip || b == 8'd0) begin
            // skip packet, or zero literal count switching to skip
            if (r_skip) begin
                n_pos  = r_pos + {8'd0, b};
                n_skip = 1'b0;
            end else begin
                n_skip = 1'b1;
            end
            n_pkts = pkts_dec;
            if (pkts_dec == 16'd0) begin
                done  = 1'b1;
                n_fin = 1'b1;
                emit  = 1'b1;
            end
        end else begin
            // literal count opens a packet
            n_lit = b;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx  <= slrd_pkg::HDR_PKT_LO;
            r_pkts     <= 16'd0;
            r_pos      <= 16'd0;
            r_lit      <= 8'd0;
            r_skip     <= 1'b0;
            r_raw_left <= 16'd0;
            r_raw      <= 1'b0;
            r_fin      <= 1'b1;
        end else if (i_step) begin
            r_hdr_idx  <= n_hdr_idx;
            r_pkts     <= n_pkts;
            r_pos      <= n_pos;
            r_lit      <= n_lit;
            r_skip     <= n_skip;
            r_raw_left <= n_raw_left;
            r_raw      <= n_raw;
            r_fin      <= n_fin;
        end
    end

    // result fields, zero where no pixel is written
    assign o_has_result         = emit;
    assign o_result.pixel_valid = pix;
    assign o_result.pixel_x     = pix ? r_pos : 16'd0;
    assign o_result.pixel_value = pix ? b : 8'd0;
    assign o_result.beyond_line = pix && (r_pos >= i_line_width);
    assign o_result.line_done   = done;

endmodule

`default_nettype wire

@@ sv/slrd_out_stage.sv @@
// slrd_out_stage: result register of the decoder toward the output channel
// depends on slrd_pkg for the result type
`default_nettype none

module slrd_out_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,        // a byte is processed this cycle
    input  wire               i_has_result,
    input  slrd_pkg::t_result i_result,
    input  wire               i_stall,
    output logic              o_free,
    output logic              o_valid,
    output slrd_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    slrd_pkg::t_result r_result;

    // free when empty or the held beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_has_result;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ sv/skip_literal_rle_line_decoder.sv @@
// skip_literal_rle_line_decoder: top level, register port and pipeline stages
// depends on slrd_pkg, slrd_in_stage, slrd_core, slrd_out_stage
//
// Usage:
//   Input channel (i_valid / o_stall) carries one byte of a compressed line per
//   beat with i_line_start marking the first header byte of a line. Output
//   channel (o_valid / i_stall) carries one pixel write or line-end marker per
//   beat; header, count and skip bytes usually give no output beat.
//   Path: an accepted byte is held in the input register, then its result is
//   registered in the result register. Throughput: one byte per cycle while
//   i_stall is low, set by the core's per-byte update between the registers.
//   Stall: a result held under i_stall still lets one more byte enter the
//   input register; o_stall rises only when both registers are occupied.
//   Reset: synchronous, active low; clears both stages, sets line_width to
//   640 and leaves the decoder idle until a byte with i_line_start.
//   line_width (address 0) is written over the APB-style port; the user must
//   do so only while idle, and the block itself does not enforce it.
`default_nettype none

module skip_literal_rle_line_decoder (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // register port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [slrd_pkg::ADDR_W-1:0]   paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  [7:0]                    i_data_byte,
    input  wire                           i_line_start,
    // output channel
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic                          o_pixel_valid,
    output logic [15:0]                   o_pixel_x,
    output logic [7:0]                    o_pixel_value,
    output logic                          o_beyond_line,
    output logic                          o_line_done
);

    logic [15:0]        r_line_width;
    logic               cfg_wr;
    slrd_pkg::t_in_beat in_beat;
    slrd_pkg::t_in_beat held_beat;
    logic               held;
    logic               out_free;
    logic               step;
    logic               has_result;
    slrd_pkg::t_result  core_result;
    slrd_pkg::t_result  out_result;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == slrd_pkg::REG_LINE_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= slrd_pkg::LINE_WIDTH_RESET;
        end else if (cfg_wr) begin
            r_line_width <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == slrd_pkg::REG_LINE_WIDTH) ? {16'd0, r_line_width} : 32'd0;

    // input register
    assign in_beat.data_byte  = i_data_byte;
    assign in_beat.line_start = i_line_start;

    slrd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_beat  (in_beat),
        .i_take  (out_free),
        .o_stall (o_stall),
        .o_held  (held),
        .o_beat  (held_beat)
    );

    // the held byte is processed when the result register can take its outcome
    assign step = held && out_free;

    slrd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_beat       (held_beat),
        .i_line_width (r_line_width),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    slrd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step),
        .i_has_result (has_result),
        .i_result     (core_result),
        .i_stall      (i_stall),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_pixel_valid = out_result.pixel_valid;
    assign o_pixel_x     = out_result.pixel_x;
    assign o_pixel_value = out_result.pixel_value;
    assign o_beyond_line = out_result.beyond_line;
    assign o_line_done   = out_result.line_done;

    // input stalls only when both stages are full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // every output beat carries a pixel or a line end
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_valid || o_line_done))
        else $error("empty result beat");

    // range flag only on pixel writes
    a_beyond_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel_valid) |-> (!o_beyond_line && o_pixel_x == 16'd0))
        else $error("range flag or position on a non-pixel beat");

    // a stalled output beat keeps its pixel position
    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && i_stall) |-> (o_valid && $stable(o_pixel_x)))
        else $error("output beat changed under stall");

endmodule

`default_nettype wire
